// ===== rtl/irpl_pkg.sv =====
// Shared types, constants and the lane calibration table for the IR range linearizer.
// No dependencies; every RTL file of the block imports this package.
`default_nettype none

package irpl_pkg;

  localparam int LANE_COUNT = 6;
  localparam int DEGREE     = 5;
  localparam int TABLE_FRAC = 20;
  localparam int DIST_BITS  = 16;

  typedef logic signed [DIST_BITS-1:0] dist_t;
  typedef logic signed [63:0]          coef_t;
  typedef coef_t                       coef_row_t [0:DEGREE];

  // Q.20 coefficients prescaled by 1024^k, index [lane][degree]
  localparam coef_row_t COEF_TABLE [0:LANE_COUNT-1] = '{
    '{ 64'sd91697971,   -64'sd1687922147, 64'sd14843406975,
      -64'sd69918384215, 64'sd166597157416, -64'sd157845099690 },
    '{ 64'sd178782208,  -64'sd2331093500, 64'sd14062753719,
      -64'sd44709485301, 64'sd71596425436, -64'sd45381941900 },
    '{ 64'sd116391936,  -64'sd2139967455, 64'sd18152936975,
      -64'sd81380045267, 64'sd184236856436, -64'sd165755063549 },
    '{ 64'sd37224448,   -64'sd74474733,   -64'sd2548667953,
       64'sd18982672429, -64'sd51650883406, 64'sd49844578227 },
    '{ 64'sd208561766,  -64'sd2732672942, 64'sd16008889300,
      -64'sd48740206967, 64'sd74570962918, -64'sd45322912319 },
    '{ 64'sd128031130,  -64'sd2719788040, 64'sd26069420695,
      -64'sd128690359352, 64'sd315324031510, -64'sd302821750714 }
  };

  // Bring a table entry to frac_bits fractional bits; magnitude rounds half away from zero.
  function automatic coef_t scaled_coef(input int lane, input int deg, input int frac_bits);
    coef_t       c;
    logic        neg;
    logic [63:0] m;
    int          sh;
    c   = COEF_TABLE[lane][deg];
    neg = c[63];
    m   = neg ? (64'd0 - c) : c;
    if (frac_bits >= TABLE_FRAC) begin
      m = m << (frac_bits - TABLE_FRAC);
    end else begin
      sh = TABLE_FRAC - frac_bits;
      m  = (m + (64'd1 << (sh - 1))) >> sh;
    end
    return neg ? coef_t'(64'd0 - m) : coef_t'(m);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/irpl_horner_step.sv =====
// One registered Horner step: acc_r = coef + round(acc_in * x / 2^SAMPLE_BITS).
// Depends on irpl_pkg for the scaled coefficient table.
`default_nettype none

module irpl_horner_step #(
  parameter int SAMPLE_BITS    = 10,
  parameter int COEF_FRAC_BITS = 20,
  parameter int ACC_W          = 42,
  parameter int LANE           = 0,
  parameter int DEG            = 0
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [ACC_W-1:0] acc_in,
  input  wire logic [SAMPLE_BITS-1:0]  x_in,
  output logic signed [ACC_W-1:0]      acc_r
);
  import irpl_pkg::*;

  localparam int    PW        = ACC_W + SAMPLE_BITS;
  localparam coef_t COEF_FULL = scaled_coef(LANE, DEG, COEF_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] COEF = $signed(COEF_FULL[ACC_W-1:0]);
  localparam logic [PW-1:0] HALF = PW'(1) << (SAMPLE_BITS - 1);

  logic                    neg;
  logic [ACC_W-1:0]        mag;
  logic [PW-1:0]           prod;
  logic [PW-1:0]           rnd;
  logic [ACC_W-1:0]        q;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    neg     = acc_in[ACC_W-1];
    mag     = neg ? (ACC_W'(0) - acc_in) : acc_in;
    prod    = PW'(mag) * PW'(x_in);
    rnd     = prod + HALF;
    q       = rnd[PW-1:SAMPLE_BITS];
    term    = neg ? -$signed(q) : $signed(q);
    acc_nxt = COEF + term;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/irpl_lane.sv =====
// One sensor lane: five pipelined Horner steps, then millimetre rounding and saturation.
// Depends on irpl_pkg and irpl_horner_step.
`default_nettype none

module irpl_lane #(
  parameter int SAMPLE_BITS    = 10,
  parameter int COEF_FRAC_BITS = 20,
  parameter int LANE           = 0
) (
  input  wire logic                   clk,
  input  wire logic [irpl_pkg::DEGREE-1:0] stage_en,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output irpl_pkg::dist_t             dist_mm
);
  import irpl_pkg::*;

  localparam int ACC_W = COEF_FRAC_BITS + 22;
  localparam int MW    = ACC_W + 4;
  localparam int RW    = MW - COEF_FRAC_BITS;
  localparam coef_t TOP_FULL = scaled_coef(LANE, DEGREE, COEF_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] TOP_COEF = $signed(TOP_FULL[ACC_W-1:0]);
  localparam logic [MW-1:0] HALF    = MW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [RW-1:0] POS_MAX = RW'(32767);
  localparam logic [RW-1:0] NEG_MAX = RW'(32768);

  logic signed [ACC_W-1:0]     acc [0:DEGREE-1];
  logic [SAMPLE_BITS-1:0]      x_r [0:DEGREE-2];

  // carry the sample alongside the accumulator
  always_ff @(posedge clk) begin
    for (int s = 0; s < DEGREE - 1; s++) begin
      if (stage_en[s]) begin
        x_r[s] <= (s == 0) ? in_sample : x_r[s == 0 ? 0 : s - 1];
      end
    end
  end

  for (genvar s = 0; s < DEGREE; s++) begin : g_step
    irpl_horner_step #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .ACC_W         (ACC_W),
      .LANE          (LANE),
      .DEG           (DEGREE - 1 - s)
    ) u_step (
      .clk   (clk),
      .en    (stage_en[s]),
      .acc_in((s == 0) ? TOP_COEF : acc[(s == 0) ? 0 : s - 1]),
      .x_in  ((s == 0) ? in_sample : x_r[(s == 0) ? 0 : s - 1]),
      .acc_r (acc[s])
    );
  end

  logic             neg;
  logic [ACC_W-1:0] mag;
  logic [MW-1:0]    m10;
  logic [RW-1:0]    mm;

  // scale cm to mm, round, clamp to 16-bit signed
  always_comb begin
    neg = acc[DEGREE-1][ACC_W-1];
    mag = neg ? (ACC_W'(0) - acc[DEGREE-1]) : acc[DEGREE-1];
    m10 = (MW'(mag) << 3) + (MW'(mag) << 1) + HALF;
    mm  = m10[MW-1:COEF_FRAC_BITS];
    if (neg) begin
      dist_mm = (mm > NEG_MAX) ? dist_t'(-32768) : dist_t'(RW'(0) - mm);
    end else begin
      dist_mm = (mm > POS_MAX) ? dist_t'(32767) : dist_t'(mm);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/irpl_merge.sv =====
// Output stage: gathers the lane distances into one registered result transaction.
// Depends on irpl_pkg for the lane count and distance type.
`default_nettype none

module irpl_merge (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 lane_valid,
  input  wire irpl_pkg::dist_t      lane_dist [irpl_pkg::LANE_COUNT],
  output logic                      stage_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output irpl_pkg::dist_t           out_dist [irpl_pkg::LANE_COUNT]
);
  import irpl_pkg::*;

  logic  out_valid_r;
  logic  out_valid_nxt;
  dist_t dist_r [LANE_COUNT];

  assign stage_ready   = !out_valid_r || out_ready;
  assign out_valid_nxt = stage_ready ? lane_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result while the sink stalls
  always_ff @(posedge clk) begin
    if (stage_ready) begin
      for (int l = 0; l < LANE_COUNT; l++) begin
        dist_r[l] <= lane_dist[l];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_dist  = dist_r;

endmodule

`default_nettype wire

// ===== rtl/ir_range_poly_linearizer.sv =====
// Six-lane IR range linearizer: quintic Horner evaluation per lane, mm rounding, saturation.
// Path: an accepted input passes through five Horner stage registers in turn (the first loading
// at the accept edge), then through the output register; a stalled out_ready holds them.
// Throughput: one transaction per cycle while out_ready does not stall; each Horner stage holds one item per lane.
// Reset (rst_n, synchronous): clears the stage valid flags and out_valid; no other state.
// Depends on irpl_pkg, irpl_lane, irpl_horner_step and irpl_merge.
`default_nettype none

module ir_range_poly_linearizer #(
  parameter int SAMPLE_BITS    = 10,
  parameter int COEF_FRAC_BITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_front_left,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_front,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_rear_left,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_rear_right,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_rear,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_front_right,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output irpl_pkg::dist_t             out_dist_front_left_mm,
  output irpl_pkg::dist_t             out_dist_front_mm,
  output irpl_pkg::dist_t             out_dist_rear_left_mm,
  output irpl_pkg::dist_t             out_dist_rear_right_mm,
  output irpl_pkg::dist_t             out_dist_rear_mm,
  output irpl_pkg::dist_t             out_dist_front_right_mm
);
  import irpl_pkg::*;

  logic [SAMPLE_BITS-1:0] samples [LANE_COUNT];
  dist_t                  lane_dist [LANE_COUNT];
  dist_t                  out_dist [LANE_COUNT];
  logic [DEGREE-1:0]      valid_r;
  logic [DEGREE-1:0]      valid_nxt;
  logic [DEGREE-1:0]      stage_en;
  logic                   merge_ready;

  assign samples[0] = in_sample_front_left;
  assign samples[1] = in_sample_front;
  assign samples[2] = in_sample_rear_left;
  assign samples[3] = in_sample_rear_right;
  assign samples[4] = in_sample_rear;
  assign samples[5] = in_sample_front_right;

  // a stage advances when it is empty or its successor advances
  always_comb begin
    stage_en[DEGREE-1] = !valid_r[DEGREE-1] || merge_ready;
    for (int s = DEGREE - 2; s >= 0; s--) begin
      stage_en[s] = !valid_r[s] || stage_en[s+1];
    end
    for (int s = 0; s < DEGREE; s++) begin
      if (stage_en[s]) begin
        valid_nxt[s] = (s == 0) ? in_valid : valid_r[(s == 0) ? 0 : s - 1];
      end else begin
        valid_nxt[s] = valid_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready = stage_en[0];

  for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
    irpl_lane #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .LANE          (l)
    ) u_lane (
      .clk      (clk),
      .stage_en (stage_en),
      .in_sample(samples[l]),
      .dist_mm  (lane_dist[l])
    );
  end

  irpl_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (valid_r[DEGREE-1]),
    .lane_dist  (lane_dist),
    .stage_ready(merge_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_dist   (out_dist)
  );

  assign out_dist_front_left_mm  = out_dist[0];
  assign out_dist_front_mm       = out_dist[1];
  assign out_dist_rear_left_mm   = out_dist[2];
  assign out_dist_rear_right_mm  = out_dist[3];
  assign out_dist_rear_mm        = out_dist[4];
  assign out_dist_front_right_mm = out_dist[5];

endmodule

`default_nettype wire
